FILE: hdl/slcan_pkg.sv
// Shared types, constants and helpers for the CAN frame to slcan ASCII encoder.
package slcan_pkg;

  localparam int unsigned AddrW = 5;

  localparam logic [AddrW-3:0] RegBusPrefix = 3'd0;
  localparam logic [AddrW-3:0] RegStdData   = 3'd1;
  localparam logic [AddrW-3:0] RegStdRemote = 3'd2;
  localparam logic [AddrW-3:0] RegExtData   = 3'd3;
  localparam logic [AddrW-3:0] RegExtRemote = 3'd4;
  localparam logic [AddrW-3:0] RegLineEnd   = 3'd5;
  localparam logic [AddrW-3:0] RegStampEn   = 3'd6;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiA    = 8'h41;
  localparam logic [3:0] MaxLen    = 4'd8;

  typedef enum logic [2:0] {
    SRC_PREFIX = 3'd0,
    SRC_BUS    = 3'd1,
    SRC_LETTER = 3'd2,
    SRC_ID     = 3'd3,
    SRC_LEN    = 3'd4,
    SRC_DATA   = 3'd5,
    SRC_STAMP  = 3'd6,
    SRC_END    = 3'd7
  } src_e;

  typedef struct packed {
    logic [7:0] bus_prefix_char;
    logic [7:0] std_data_char;
    logic [7:0] std_remote_char;
    logic [7:0] ext_data_char;
    logic [7:0] ext_remote_char;
    logic [7:0] line_end_char;
    logic       stamp_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic emit;
    src_e src;
  } cmd_t;

  typedef struct packed {
    logic       ext;
    logic [3:0] len;
    logic       out_free;
  } stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'h0, nib};
    return (nib > 4'd9) ? (AsciiA + n8 - 8'd10) : (AsciiZero + n8);
  endfunction

endpackage

FILE: hdl/slcan_frame_if.sv
// Input channel carrying one CAN frame per beat.
interface slcan_frame_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bus_number;
  logic [28:0] frame_id;
  logic        remote_flag;
  logic [3:0]  data_len;
  logic [63:0] payload;
  logic [15:0] time_stamp;

  modport source (output valid, bus_number, frame_id, remote_flag, data_len, payload,
                  time_stamp, input ready);
  modport sink (input valid, bus_number, frame_id, remote_flag, data_len, payload,
                time_stamp, output ready);
endinterface

FILE: hdl/slcan_char_if.sv
// Output channel carrying one ASCII character per beat.
interface slcan_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink (input valid, out_char, last_char, output ready);
endinterface

FILE: hdl/slcan_regs.sv
// APB configuration register file.
module slcan_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [slcan_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output slcan_pkg::cfg_t            cfg_o
);

  slcan_pkg::cfg_t cfg_q, cfg_d;
  logic [slcan_pkg::AddrW-3:0] idx;
  logic wr;

  assign pready = 1'b1;
  assign idx    = paddr[slcan_pkg::AddrW-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        slcan_pkg::RegBusPrefix: cfg_d.bus_prefix_char = pwdata[7:0];
        slcan_pkg::RegStdData:   cfg_d.std_data_char   = pwdata[7:0];
        slcan_pkg::RegStdRemote: cfg_d.std_remote_char = pwdata[7:0];
        slcan_pkg::RegExtData:   cfg_d.ext_data_char   = pwdata[7:0];
        slcan_pkg::RegExtRemote: cfg_d.ext_remote_char = pwdata[7:0];
        slcan_pkg::RegLineEnd:   cfg_d.line_end_char   = pwdata[7:0];
        slcan_pkg::RegStampEn:   cfg_d.stamp_enable    = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      slcan_pkg::RegBusPrefix: prdata = {24'h0, cfg_q.bus_prefix_char};
      slcan_pkg::RegStdData:   prdata = {24'h0, cfg_q.std_data_char};
      slcan_pkg::RegStdRemote: prdata = {24'h0, cfg_q.std_remote_char};
      slcan_pkg::RegExtData:   prdata = {24'h0, cfg_q.ext_data_char};
      slcan_pkg::RegExtRemote: prdata = {24'h0, cfg_q.ext_remote_char};
      slcan_pkg::RegLineEnd:   prdata = {24'h0, cfg_q.line_end_char};
      slcan_pkg::RegStampEn:   prdata = {31'h0, cfg_q.stamp_enable};
      default:                 prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bus_prefix_char <= 8'd66;
      cfg_q.std_data_char   <= 8'd116;
      cfg_q.std_remote_char <= 8'd114;
      cfg_q.ext_data_char   <= 8'd84;
      cfg_q.ext_remote_char <= 8'd82;
      cfg_q.line_end_char   <= 8'd13;
      cfg_q.stamp_enable    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/slcan_dp.sv
// Datapath: frame capture, digit shifters, character mux and output register.
module slcan_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slcan_pkg::cfg_t   cfg_i,
  input  slcan_pkg::cmd_t   cmd_i,
  output slcan_pkg::stat_t  stat_o,
  slcan_frame_if.sink       frame_i,
  slcan_char_if.source      char_o
);

  logic [1:0]  bus_q;
  logic        ext_q, remote_q;
  logic [3:0]  len_q;
  logic [31:0] id_sh_q;
  logic [63:0] pay_sh_q;
  logic [15:0] stamp_sh_q;
  logic        out_valid_q;
  logic [7:0]  char_q, char_d;
  logic        last_q;
  logic        ext_d;
  logic        out_free;

  assign ext_d    = |frame_i.frame_id[28:11];
  assign out_free = !out_valid_q || char_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bus_q      <= frame_i.bus_number;
      ext_q      <= ext_d;
      remote_q   <= frame_i.remote_flag;
      len_q      <= (frame_i.data_len > slcan_pkg::MaxLen) ? slcan_pkg::MaxLen
                                                           : frame_i.data_len;
      id_sh_q    <= ext_d ? {3'b000, frame_i.frame_id}
                          : {frame_i.frame_id[11:0], 20'h0};
      pay_sh_q   <= frame_i.payload;
      stamp_sh_q <= frame_i.time_stamp;
    end else if (cmd_i.emit) begin
      if (cmd_i.src == slcan_pkg::SRC_ID)    id_sh_q    <= {id_sh_q[27:0], 4'h0};
      if (cmd_i.src == slcan_pkg::SRC_DATA)  pay_sh_q   <= {pay_sh_q[59:0], 4'h0};
      if (cmd_i.src == slcan_pkg::SRC_STAMP) stamp_sh_q <= {stamp_sh_q[11:0], 4'h0};
    end
  end

  always_comb begin
    case (cmd_i.src)
      slcan_pkg::SRC_PREFIX: char_d = cfg_i.bus_prefix_char;
      slcan_pkg::SRC_BUS:    char_d = slcan_pkg::AsciiZero + {6'h0, bus_q};
      slcan_pkg::SRC_LETTER: begin
        if (ext_q) char_d = remote_q ? cfg_i.ext_remote_char : cfg_i.ext_data_char;
        else       char_d = remote_q ? cfg_i.std_remote_char : cfg_i.std_data_char;
      end
      slcan_pkg::SRC_ID:     char_d = slcan_pkg::hex_char(id_sh_q[31:28]);
      slcan_pkg::SRC_LEN:    char_d = slcan_pkg::AsciiZero + {4'h0, len_q};
      slcan_pkg::SRC_DATA:   char_d = slcan_pkg::hex_char(pay_sh_q[63:60]);
      slcan_pkg::SRC_STAMP:  char_d = slcan_pkg::hex_char(stamp_sh_q[15:12]);
      slcan_pkg::SRC_END:    char_d = cfg_i.line_end_char;
      default:               char_d = 8'h0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= (cmd_i.src == slcan_pkg::SRC_END);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (char_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign char_o.valid     = out_valid_q;
  assign char_o.out_char  = char_q;
  assign char_o.last_char = last_q;

  assign stat_o.ext      = ext_q;
  assign stat_o.len      = len_q;
  assign stat_o.out_free = out_free;

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("character emitted over an untaken beat");

  a_end_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.src == slcan_pkg::SRC_END) |=> (out_valid_q && last_q))
    else $error("terminator beat not flagged last");

endmodule

FILE: hdl/slcan_ctrl.sv
// Character sequencer state machine.
module slcan_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_valid_i,
  output logic             frame_ready_o,
  input  logic             stamp_en_i,
  input  slcan_pkg::stat_t stat_i,
  output slcan_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PREFIX = 9'b000000010,
    S_BUS    = 9'b000000100,
    S_LETTER = 9'b000001000,
    S_ID     = 9'b000010000,
    S_LEN    = 9'b000100000,
    S_DATA   = 9'b001000000,
    S_STAMP  = 9'b010000000,
    S_END    = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       accept, adv;
  slcan_pkg::src_e src;

  assign frame_ready_o = (state_q == S_IDLE);
  assign accept        = frame_valid_i && frame_ready_o;
  assign adv           = (state_q != S_IDLE) && stat_i.out_free;

  always_comb begin
    case (state_q)
      S_PREFIX: src = slcan_pkg::SRC_PREFIX;
      S_BUS:    src = slcan_pkg::SRC_BUS;
      S_LETTER: src = slcan_pkg::SRC_LETTER;
      S_ID:     src = slcan_pkg::SRC_ID;
      S_LEN:    src = slcan_pkg::SRC_LEN;
      S_DATA:   src = slcan_pkg::SRC_DATA;
      S_STAMP:  src = slcan_pkg::SRC_STAMP;
      S_END:    src = slcan_pkg::SRC_END;
      default:  src = slcan_pkg::SRC_PREFIX;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_PREFIX;
      S_PREFIX: if (adv) state_d = S_BUS;
      S_BUS:    if (adv) state_d = S_LETTER;
      S_LETTER: if (adv) begin
        state_d = S_ID;
        cnt_d   = stat_i.ext ? 4'd7 : 4'd2;
      end
      S_ID:     if (adv) begin
        if (cnt_q == 4'd0) state_d = S_LEN;
        else cnt_d = cnt_q - 4'd1;
      end
      S_LEN:    if (adv) begin
        if (stat_i.len != 4'd0) begin
          state_d = S_DATA;
          cnt_d   = 4'({stat_i.len, 1'b0} - 5'd1);
        end else if (stamp_en_i) begin
          state_d = S_STAMP;
          cnt_d   = 4'd3;
        end else begin
          state_d = S_END;
        end
      end
      S_DATA:   if (adv) begin
        if (cnt_q != 4'd0) begin
          cnt_d = cnt_q - 4'd1;
        end else if (stamp_en_i) begin
          state_d = S_STAMP;
          cnt_d   = 4'd3;
        end else begin
          state_d = S_END;
        end
      end
      S_STAMP:  if (adv) begin
        if (cnt_q == 4'd0) state_d = S_END;
        else cnt_d = cnt_q - 4'd1;
      end
      S_END:    if (adv) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cmd_o.load = accept;
  assign cmd_o.emit = adv;
  assign cmd_o.src  = src;

  a_accept_starts_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_PREFIX))
    else $error("accepted frame did not start a line");

  a_data_needs_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> (stat_i.len != 4'd0))
    else $error("data digits for an empty frame");

  a_std_id_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ID && !stat_i.ext) |-> (cnt_q <= 4'd2))
    else $error("standard id digit count overrun");

endmodule

FILE: hdl/can_frame_to_slcan_ascii_unit.sv
// Top level of the CAN frame to slcan ASCII line encoder.
//   channel   | dir | beat
//   frame_i   | in  | one CAN frame: bus, id, remote, length, payload, stamp
//   char_o    | out | one ASCII character, last_char on the terminator
//   apb       | in  | register writes and reads, 4-byte stride
// A line is 8 to 33 characters, one per cycle from the sequencer in slcan_ctrl while
// char_o is not stalled; a frame occupies the unit until its terminator is emitted.
// The next frame is taken while the terminator still waits in the output register.
// A stall on char_o holds the sequencer; reset empties the output and returns to idle.
module can_frame_to_slcan_ascii_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  slcan_frame_if.sink                 frame_i,
  slcan_char_if.source                char_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slcan_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  slcan_pkg::cfg_t  cfg;
  slcan_pkg::cmd_t  cmd;
  slcan_pkg::stat_t stat;

  slcan_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slcan_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_i.valid),
    .frame_ready_o (frame_i.ready),
    .stamp_en_i    (cfg.stamp_enable),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  slcan_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .frame_i (frame_i),
    .char_o  (char_o)
  );

endmodule

FILE: tb/sv/slcan_line_checker.sv
// Checker for the slcan line encoder: tracks register writes, predicts each text line and compares.
`timescale 1ns / 1ps

module slcan_line_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  slcan_frame_if                      frame_mon,
  slcan_char_if                       char_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slcan_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int unsigned                 mismatch_count,
  output int unsigned                 chars_pending
);

  localparam logic [28:0] StdIdMax = 29'd2047;
  localparam slcan_pkg::cfg_t CfgReset = {8'd66, 8'd116, 8'd114, 8'd84, 8'd82, 8'd13, 1'b0};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  slcan_pkg::cfg_t line_cfg;
  text_beat_t      expected_text[$];
  int unsigned     fails;

  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) return slcan_pkg::AsciiZero + {4'd0, nib};
    return slcan_pkg::AsciiA + {4'd0, nib - 4'd10};
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic last);
    text_beat_t b;
    b.ch   = c;
    b.last = last;
    expected_text.push_back(b);
  endfunction

  function automatic void predict_line(input logic [1:0] bus, input logic [28:0] id,
                                       input logic remote, input logic [3:0] len_raw,
                                       input logic [63:0] data, input logic [15:0] stamp);
    logic [3:0]  len;
    logic [31:0] id32;
    logic [7:0]  byte_val;
    len  = (len_raw > slcan_pkg::MaxLen) ? slcan_pkg::MaxLen : len_raw;
    id32 = {3'd0, id};
    push_char(line_cfg.bus_prefix_char, 1'b0);
    push_char(slcan_pkg::AsciiZero + {6'd0, bus}, 1'b0);
    if (id > StdIdMax) begin
      push_char(remote ? line_cfg.ext_remote_char : line_cfg.ext_data_char, 1'b0);
      for (int i = 7; i >= 0; i--) push_char(nibble_ascii(id32[4*i +: 4]), 1'b0);
    end else begin
      push_char(remote ? line_cfg.std_remote_char : line_cfg.std_data_char, 1'b0);
      for (int i = 2; i >= 0; i--) push_char(nibble_ascii(id32[4*i +: 4]), 1'b0);
    end
    push_char(slcan_pkg::AsciiZero + {4'd0, len}, 1'b0);
    for (int i = 0; i < int'(len); i++) begin
      byte_val = data[63-8*i -: 8];
      push_char(nibble_ascii(byte_val[7:4]), 1'b0);
      push_char(nibble_ascii(byte_val[3:0]), 1'b0);
    end
    if (line_cfg.stamp_enable) begin
      for (int i = 3; i >= 0; i--) push_char(nibble_ascii(stamp[4*i +: 4]), 1'b0);
    end
    push_char(line_cfg.line_end_char, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t want;
    if (!rst_ni) begin
      line_cfg = CfgReset;
      expected_text.delete();
      fails = 0;
      mismatch_count <= 0;
      chars_pending  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[slcan_pkg::AddrW-1:2])
          slcan_pkg::RegBusPrefix: line_cfg.bus_prefix_char = pwdata[7:0];
          slcan_pkg::RegStdData:   line_cfg.std_data_char   = pwdata[7:0];
          slcan_pkg::RegStdRemote: line_cfg.std_remote_char = pwdata[7:0];
          slcan_pkg::RegExtData:   line_cfg.ext_data_char   = pwdata[7:0];
          slcan_pkg::RegExtRemote: line_cfg.ext_remote_char = pwdata[7:0];
          slcan_pkg::RegLineEnd:   line_cfg.line_end_char   = pwdata[7:0];
          slcan_pkg::RegStampEn:   line_cfg.stamp_enable    = pwdata[0];
          default: ;
        endcase
      end
      if (char_mon.valid && char_mon.ready) begin
        if (expected_text.size() == 0) begin
          $error("out_char beat %02h with no line pending", char_mon.out_char);
          fails++;
        end else begin
          want = expected_text.pop_front();
          if (char_mon.out_char !== want.ch) begin
            $error("out_char mismatch: expected %02h, actual %02h", want.ch, char_mon.out_char);
            fails++;
          end
          if (char_mon.last_char !== want.last) begin
            $error("last_char mismatch: expected %0b, actual %0b", want.last,
                   char_mon.last_char);
            fails++;
          end
        end
      end
      if (frame_mon.valid && frame_mon.ready) begin
        predict_line(frame_mon.bus_number, frame_mon.frame_id, frame_mon.remote_flag,
                     frame_mon.data_len, frame_mon.payload, frame_mon.time_stamp);
      end
      mismatch_count <= fails;
      chars_pending  <= expected_text.size();
    end
  end

endmodule

FILE: tb/sv/can_frame_to_slcan_ascii_unit_test.sv
// Top of the slcan line encoder test: clock, reset, frame and register stimulus, verdict.
`timescale 1ns / 1ps

module can_frame_to_slcan_ascii_unit_test;

  localparam logic [slcan_pkg::AddrW-3:0] RegUnused = 3'd7;
  localparam int unsigned LongStall = 400;

  typedef struct packed {
    logic [1:0]  bus;
    logic [28:0] id;
    logic        remote;
    logic [3:0]  len;
    logic [63:0] data;
    logic [15:0] stamp;
  } frame_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [slcan_pkg::AddrW-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        long_stall_req;
  int unsigned                 mismatch_count;
  int unsigned                 chars_pending;

  slcan_frame_if frame_bus();
  slcan_char_if  char_bus();

  can_frame_to_slcan_ascii_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_bus),
    .char_o  (char_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slcan_line_checker line_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_mon      (frame_bus),
    .char_mon       (char_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int unsigned sel;
    f.bus = 2'($urandom_range(0, 3));
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      f.id = 29'($urandom_range(0, 2047));
    end else if (sel == 3) begin
      case ($urandom_range(0, 3))
        0: f.id = 29'd0;
        1: f.id = 29'd2047;
        2: f.id = 29'd2048;
        default: f.id = '1;
      endcase
    end else begin
      f.id = 29'($urandom);
    end
    f.remote = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) f.len = 4'($urandom_range(9, 15));
    else f.len = 4'($urandom_range(0, 8));
    f.data  = {$urandom, $urandom};
    f.stamp = 16'($urandom);
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      frame_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_bus.valid       <= 1'b1;
    frame_bus.bus_number  <= f.bus;
    frame_bus.frame_id    <= f.id;
    frame_bus.remote_flag <= f.remote;
    frame_bus.data_len    <= f.len;
    frame_bus.payload     <= f.data;
    frame_bus.time_stamp  <= f.stamp;
    do @(posedge clk_i); while (!frame_bus.ready);
  endtask

  // close a phase: stop offering frames and let every pending character drain
  task automatic drain_lines();
    frame_bus.valid <= 1'b0;
    do @(posedge clk_i); while (chars_pending != 0);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_frame(rand_frame());
    drain_lines();
  endtask

  task automatic reg_write(input logic [slcan_pkg::AddrW-3:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [31:0] prefix, input logic [31:0] std_data,
                            input logic [31:0] std_remote, input logic [31:0] ext_data,
                            input logic [31:0] ext_remote, input logic [31:0] line_end,
                            input logic [31:0] stamp_en);
    reg_write(slcan_pkg::RegBusPrefix, prefix);
    reg_write(slcan_pkg::RegStdData, std_data);
    reg_write(slcan_pkg::RegStdRemote, std_remote);
    reg_write(slcan_pkg::RegExtData, ext_data);
    reg_write(slcan_pkg::RegExtRemote, ext_remote);
    reg_write(slcan_pkg::RegLineEnd, line_end);
    reg_write(slcan_pkg::RegStampEn, stamp_en);
  endtask

  // output side: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned run_len;
    int unsigned gap;
    logic        long_stall_done;
    long_stall_done = 1'b0;
    char_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_stall_req && !long_stall_done) begin
        long_stall_done = 1'b1;
        char_bus.ready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
      end else begin
        run_len = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 12);
        char_bus.ready <= 1'b1;
        repeat (run_len) @(posedge clk_i);
        gap = pick_gap();
        if (gap != 0) begin
          char_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    frame_bus.valid       <= 1'b0;
    frame_bus.bus_number  <= '0;
    frame_bus.frame_id    <= '0;
    frame_bus.remote_flag <= 1'b0;
    frame_bus.data_len    <= '0;
    frame_bus.payload     <= '0;
    frame_bus.time_stamp  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    long_stall_req <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, no time stamp
    send_frame({2'd0, 29'd0, 1'b0, 4'd0, 64'h0, 16'h0});
    send_frame({2'd1, 29'd2047, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF});
    send_frame({2'd2, 29'd2048, 1'b0, 4'd8, 64'h0123_4567_89AB_CDEF, 16'h0});
    send_frame({2'd3, 29'h1FFF_FFFF, 1'b1, 4'd0, 64'h0, 16'h0});
    send_frame({2'd0, 29'h7FF, 1'b0, 4'd9, 64'hFEDC_BA98_7654_3210, 16'h0});
    send_frame({2'd1, 29'h1ABC_DEF0, 1'b0, 4'd15, 64'hA5A5_5A5A_0F0F_F0F0, 16'h0});
    send_frame({2'd2, 29'h123, 1'b1, 4'd3, 64'hDEAD_BEEF_0000_0000, 16'h0});
    send_frame({2'd3, 29'h1000_0000, 1'b1, 4'd1, 64'hA500_0000_0000_0000, 16'h0});
    send_frame({2'd0, 29'h0000_0ABC, 1'b0, 4'd2, 64'h9AF0_0000_0000_0000, 16'h0});
    send_frame({2'd1, 29'h001, 1'b0, 4'd5, 64'h1234_5678_9A00_0000, 16'h0});
    drain_lines();

    // time stamp on, written with upper bits set
    reg_write(slcan_pkg::RegStampEn, 32'hFFFF_FFFF);
    send_frame({2'd0, 29'd0, 1'b0, 4'd0, 64'h0, 16'h0000});
    send_frame({2'd3, 29'h1FFF_FFFF, 1'b1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF});
    send_frame({2'd2, 29'd2047, 1'b0, 4'd4, 64'h0011_2233_4455_6677, 16'h1234});
    send_frame({2'd1, 29'd2048, 1'b0, 4'd8, 64'h8899_AABB_CCDD_EEFF, 16'hABCD});
    drain_lines();
    long_stall_req <= 1'b1;
    run_random(50);

    // all zero characters from values whose upper bits are set; unused index must be ignored
    write_regs(32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FF00,
               32'hFFFF_FF00, 32'hFFFF_FFFE);
    reg_write(RegUnused, 32'h0000_0055);
    run_random(50);

    write_regs(32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF,
               32'h0000_00FF, 32'h0000_0001);
    run_random(50);

    write_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               32'($urandom_range(0, 1)));
    run_random(35);
    write_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               32'($urandom_range(0, 1)));
    run_random(35);

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(15_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
